// File: sv/fpae_pkg.sv
// Shared types and constants for the FASTA parser / alphabet encoder.
// No dependencies; imported by every module of the block.
package fpae_pkg;

	localparam int ALPHABET_SLOTS = 128;
	localparam int BYTE_W = 8;
	localparam int SYM_W = 7;
	localparam int COUNT_W = 8;
	localparam int LETTER_DEPTH = 128;

	localparam logic [BYTE_W-1:0] CH_HEADER = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

	// table insert request from the parser to the alphabet
	typedef struct packed {
		logic             en;
		logic [SYM_W-1:0] addr;
	} fpae_wr_t;

	// one parsed result
	typedef struct packed {
		logic             emit;
		logic             bad;
		logic [SYM_W-1:0] sym;
		logic             starts;
		logic             fresh;
		logic [SYM_W-1:0] letter;
	} fpae_res_t;

endpackage

// File: sv/fasta_parser_alphabet_encoder_core.sv
// Top level of the FASTA parser / alphabet encoder.
// Depends on fpae_pkg, fpae_alphabet and fpae_parse.
//
// Input stream: one byte of FASTA text per transaction; s_axis_tuser marks the
// first byte of a new file, which clears header and sequence tracking but keeps
// the alphabet. Output stream: one transaction per residue (or bad byte);
// header text, '>' and CR/LF produce no output.
// Pipeline: input register (stage 1, with the code memory read) followed by
// the result register. A byte accepted into stage 1 reaches the output when
// it moves into the result register. While the receiver does not stall, one
// byte per cycle is sustained, set by the single table read-and-update per byte in stage 1.
// When the receiver stalls, the result register holds and stage 1 holds its
// byte; s_axis_tready drops only when both are full.
// Reset clears the header/sequence flags, the known-letter bits and the
// alphabet count; the code memory needs no clearing (entries are read only
// once their known bit is set).
module fasta_parser_alphabet_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
	input  logic        s_axis_tuser,   // [0] file_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [6:0] symbol_index, [7] starts_sequence,
	                                    // [8] new_letter, [15:9] letter_byte
	output logic        m_axis_tuser    // [0] bad_byte
);
	import fpae_pkg::*;

	logic                valid_s1, first_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                out_free, fire, load;
	logic                known;
	logic [SYM_W-1:0]    code_s1;
	logic [COUNT_W-1:0]  count;
	fpae_res_t           res;
	fpae_wr_t            wr;
	logic                valid_s2, bad_s2;
	logic [15:0]         data_s2;

	assign out_free = ~valid_s2 | m_axis_tready;
	assign fire = valid_s1 & out_free;
	assign s_axis_tready = ~valid_s1 | out_free;
	assign load = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= s_axis_tdata;
			first_s1 <= s_axis_tuser;
		end
	end

	fpae_alphabet u_alphabet (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (load),
		.rd_addr    (s_axis_tdata[SYM_W-1:0]),
		.look_addr  (byte_s1[SYM_W-1:0]),
		.wr         (wr),
		.known      (known),
		.rd_code_s1 (code_s1),
		.count      (count)
	);

	fpae_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.byte_s1  (byte_s1),
		.first_s1 (first_s1),
		.known    (known),
		.code     (code_s1),
		.count    (count),
		.res      (res),
		.wr       (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (out_free)
			valid_s2 <= fire & res.emit;
	end

	always_ff @(posedge clk) begin
		if (fire && res.emit) begin
			data_s2 <= {res.letter, res.fresh, res.starts, res.sym};
			bad_s2 <= res.bad;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = data_s2;
	assign m_axis_tuser = bad_s2;

`ifndef SYNTHESIS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && bad_s2 |-> data_s2 == '0)
		else $error("bad-byte result carries nonzero fields");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count} <= (COUNT_W+1)'(ALPHABET_SLOTS))
		else $error("alphabet count beyond slot limit");

	a_new_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !bad_s2 && data_s2[8] |->
		data_s2[SYM_W-1:0] == SYM_W'(count - COUNT_W'(1)))
		else $error("new letter code does not match alphabet count");
`endif

endmodule

// File: sv/fpae_alphabet.sv
// Alphabet table: per-letter known bits, code memory and alphabet count.
// Depends on fpae_pkg.
module fpae_alphabet (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [fpae_pkg::SYM_W-1:0]    rd_addr,
	input  logic [fpae_pkg::SYM_W-1:0]    look_addr,
	input  fpae_pkg::fpae_wr_t            wr,
	output logic                          known,
	output logic [fpae_pkg::SYM_W-1:0]    rd_code_s1,
	output logic [fpae_pkg::COUNT_W-1:0]  count
);
	import fpae_pkg::*;

	logic [LETTER_DEPTH-1:0]  known_q;
	logic [SYM_W-1:0]         code_mem [LETTER_DEPTH];
	logic [COUNT_W-1:0]       count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= '0;
			count_q <= '0;
		end else if (wr.en) begin
			known_q[wr.addr] <= 1'b1;
			count_q <= count_q + COUNT_W'(1);
		end
	end

	// code read is registered with the item entering stage 1; bypass a same-cycle insert
	always_ff @(posedge clk) begin
		if (wr.en)
			code_mem[wr.addr] <= count_q[SYM_W-1:0];
		if (rd_en) begin
			if (wr.en && wr.addr == rd_addr)
				rd_code_s1 <= count_q[SYM_W-1:0];
			else
				rd_code_s1 <= code_mem[rd_addr];
		end
	end

	assign known = known_q[look_addr];
	assign count = count_q;

endmodule

// File: sv/fpae_parse.sv
// Byte classifier and header/sequence tracking for one stage-1 item.
// Depends on fpae_pkg; drives inserts into fpae_alphabet.
module fpae_parse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [fpae_pkg::BYTE_W-1:0]   byte_s1,
	input  logic                          first_s1,
	input  logic                          known,
	input  logic [fpae_pkg::SYM_W-1:0]    code,
	input  logic [fpae_pkg::COUNT_W-1:0]  count,
	output fpae_pkg::fpae_res_t           res,
	output fpae_pkg::fpae_wr_t            wr
);
	import fpae_pkg::*;

	logic in_header_q, in_sequence_q;
	logic hdr, seq, hdr_nxt, seq_nxt, full, insert;

	assign full = {1'b0, count} >= (COUNT_W+1)'(ALPHABET_SLOTS);

	always_comb begin
		hdr = in_header_q & ~first_s1;
		seq = in_sequence_q & ~first_s1;
		hdr_nxt = hdr;
		seq_nxt = seq;
		insert = 1'b0;
		res = '0;
		if (hdr) begin
			hdr_nxt = (byte_s1 != CH_LF);
		end else if (byte_s1 == CH_HEADER) begin
			hdr_nxt = 1'b1;
			seq_nxt = 1'b0;
		end else if (byte_s1 == CH_CR || byte_s1 == CH_LF) begin
			res.emit = 1'b0;
		end else if (byte_s1[BYTE_W-1]) begin
			res.emit = 1'b1;
			res.bad = 1'b1;
		end else if (!known && full) begin
			res.emit = 1'b1;
			res.bad = 1'b1;
		end else begin
			insert = ~known;
			res.emit = 1'b1;
			res.sym = known ? code : count[SYM_W-1:0];
			res.starts = ~seq;
			res.fresh = ~known;
			res.letter = byte_s1[SYM_W-1:0];
			seq_nxt = 1'b1;
		end
	end

	assign wr.en = fire & insert;
	assign wr.addr = byte_s1[SYM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q <= 1'b0;
			in_sequence_q <= 1'b0;
		end else if (fire) begin
			in_header_q <= hdr_nxt;
			in_sequence_q <= seq_nxt;
		end
	end

endmodule
